### rtl/csi_mvd_pkg.sv
// Shared types, sizes and exponent tables of the CSI motion variance detector.
// Used by every module of the block; depends on nothing.
package csi_mvd_pkg;

    localparam int NSC     = 64;
    localparam int WMAX    = 32;
    localparam int SC_W    = (NSC > 1) ? $clog2(NSC) : 1;
    localparam int SLOT_W  = $clog2(WMAX);
    localparam int WS_W    = $clog2(WMAX + 1);
    localparam int ADDR_W  = $clog2(WMAX * NSC);
    localparam int AMP_W   = 16;
    localparam int S_W     = AMP_W + WS_W;
    localparam int Q_W     = 2 * AMP_W + WS_W;
    localparam int NQ_W    = Q_W + WS_W;
    localparam int S2_W    = 2 * S_W;
    localparam int FRAC_W  = 24;
    localparam int DNUM_W  = NQ_W + FRAC_W;
    localparam int DDEN_W  = S2_W;
    localparam int QUO_W   = 32;
    localparam int DCNT_W  = $clog2(QUO_W + 1);
    localparam int ACT_W   = $clog2(NSC + 1);
    localparam int TOT_W   = QUO_W + ACT_W;
    localparam int CSUM_W  = 40;
    localparam int THR_W   = 24;
    localparam int CFG_W   = 24;
    localparam int R_SAT   = 12 * 256;

    localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [1:0] FUNC_COMPUTE = 2'd1;
    localparam logic [1:0] FUNC_CALIB   = 2'd2;

    localparam logic CFG_WINDOW_SIZE   = 1'b0;
    localparam logic CFG_CV2_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_COMPUTE,
        CMD_CALIB
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [AMP_W-1:0]   amplitude;
        logic signed [7:0]  rssi;
        logic [15:0]        calib_seconds;
    } t_item;

    typedef struct packed {
        logic               we;
        logic               idx;
        logic [CFG_W-1:0]   data;
    } t_cfg_wr;

    typedef struct packed {
        logic               start;
        logic [DNUM_W-1:0]  num;
        logic [DDEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quot;
    } t_div_rsp;

    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] h);
        logic [16:0] v;
        case (h)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] l);
        logic [16:0] v;
        case (l)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62780;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

### rtl/csi_mvd_front.sv
// Front end: accepts items, decodes the function code, drops unused codes
// and holds decoded items in a two-entry queue. Depends on csi_mvd_pkg.
module csi_mvd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [1:0]              i_func,
    input  logic [15:0]             i_amplitude,
    input  logic signed [7:0]       i_rssi,
    input  logic [15:0]             i_calib_seconds,
    output logic                    o_item_valid,
    output csi_mvd_pkg::t_item      o_item,
    input  logic                    i_item_take
);

    csi_mvd_pkg::t_item r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    csi_mvd_pkg::t_item n_item;
    logic               n_keep;
    logic               wr;
    logic               rd;

    always_comb begin
        n_item.amplitude     = i_amplitude;
        n_item.rssi          = i_rssi;
        n_item.calib_seconds = i_calib_seconds;
        n_item.cmd           = csi_mvd_pkg::CMD_SAMPLE;
        n_keep               = 1'b1;
        case (i_func)
            csi_mvd_pkg::FUNC_SAMPLE:  n_item.cmd = csi_mvd_pkg::CMD_SAMPLE;
            csi_mvd_pkg::FUNC_COMPUTE: n_item.cmd = csi_mvd_pkg::CMD_COMPUTE;
            csi_mvd_pkg::FUNC_CALIB:   n_item.cmd = csi_mvd_pkg::CMD_CALIB;
            default:                   n_keep     = 1'b0;
        endcase
    end

    assign o_full       = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign wr           = i_push && !o_full && n_keep;
    assign rd           = o_item_valid && i_item_take;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

### rtl/csi_mvd_div.sv
// Shared restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on csi_mvd_pkg.
module csi_mvd_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  csi_mvd_pkg::t_div_req   i_req,
    output csi_mvd_pkg::t_div_rsp   o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [csi_mvd_pkg::DCNT_W-1:0]     r_cnt;
    logic [csi_mvd_pkg::DDEN_W-1:0]     r_rem;
    logic [csi_mvd_pkg::DDEN_W-1:0]     r_den;
    logic [csi_mvd_pkg::QUO_W-1:0]      r_low;
    logic [csi_mvd_pkg::QUO_W-1:0]      r_quot;
    logic [csi_mvd_pkg::DDEN_W-1:0]     hi;
    logic [csi_mvd_pkg::DDEN_W:0]       trial;
    logic                               ge;

    assign hi    = csi_mvd_pkg::DDEN_W'(i_req.num >> csi_mvd_pkg::QUO_W);
    assign trial = {r_rem, r_low[csi_mvd_pkg::QUO_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_den <= i_req.den;
                r_rem <= hi;
                r_low <= i_req.num[csi_mvd_pkg::QUO_W-1:0];
                if (hi >= i_req.den) begin
                    // quotient does not fit: saturate at once
                    r_quot <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_quot <= '0;
                    r_cnt  <= csi_mvd_pkg::DCNT_W'(csi_mvd_pkg::QUO_W);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= ge ? csi_mvd_pkg::DDEN_W'(trial - {1'b0, r_den})
                             : csi_mvd_pkg::DDEN_W'(trial);
                r_low  <= r_low << 1;
                r_quot <= {r_quot[csi_mvd_pkg::QUO_W-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == csi_mvd_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/csi_mvd_back.sv
// Back end: window memory, frame bookkeeping, calibration and the compute
// sequencer with its result register. Depends on csi_mvd_pkg and csi_mvd_div.
module csi_mvd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  csi_mvd_pkg::t_cfg_wr    i_cfg,
    input  logic                    i_item_valid,
    input  csi_mvd_pkg::t_item      i_item,
    output logic                    o_item_take,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic                    o_status,
    output logic [15:0]             o_move_prob,
    output logic signed [7:0]       o_last_rssi,
    output logic                    o_calibrating
);

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_ACC  = 13'b0000000000010,
        ST_SQ   = 13'b0000000000100,
        ST_CHK  = 13'b0000000001000,
        ST_DIV  = 13'b0000000010000,
        ST_NEXT = 13'b0000000100000,
        ST_AVG  = 13'b0000001000000,
        ST_POST = 13'b0000010000000,
        ST_CAL2 = 13'b0000100000000,
        ST_EXP1 = 13'b0001000000000,
        ST_EXP2 = 13'b0010000000000,
        ST_EXP3 = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } t_state;

    typedef enum logic [1:0] {
        DK_CV2,
        DK_AVG,
        DK_BASE,
        DK_PROB
    } t_div_kind;

    localparam int WS_W   = csi_mvd_pkg::WS_W;
    localparam int ADDR_W = csi_mvd_pkg::ADDR_W;

    t_state                             r_state;
    t_div_kind                          r_kind;
    logic [15:0]                        mem [csi_mvd_pkg::WMAX * csi_mvd_pkg::NSC];
    logic [15:0]                        r_rd_data;

    logic [WS_W-1:0]                    r_ws;
    logic [csi_mvd_pkg::THR_W-1:0]      r_thr;
    logic [csi_mvd_pkg::SLOT_W-1:0]     r_slot;
    logic [csi_mvd_pkg::SC_W-1:0]       r_sub;
    logic                               r_full;
    logic [WS_W-1:0]                    r_fc;
    logic signed [7:0]                  r_rssi;
    logic                               r_seen;
    logic                               r_cal_act;
    logic [15:0]                        r_cal_tgt;
    logic [15:0]                        r_cal_cnt;
    logic [csi_mvd_pkg::CSUM_W-1:0]     r_cal_sum;
    logic [31:0]                        r_base;

    logic [csi_mvd_pkg::SC_W-1:0]       r_sc;
    logic [WS_W-1:0]                    r_i;
    logic                               r_pend;
    logic [csi_mvd_pkg::S_W-1:0]        r_s;
    logic [csi_mvd_pkg::Q_W-1:0]        r_q;
    logic [csi_mvd_pkg::S2_W-1:0]       r_s2;
    logic [csi_mvd_pkg::NQ_W-1:0]       r_nq;
    logic [csi_mvd_pkg::TOT_W-1:0]      r_tot;
    logic [csi_mvd_pkg::ACT_W-1:0]      r_act;
    logic [31:0]                        r_avg;
    logic [11:0]                        r_r;
    logic [33:0]                        r_e1;
    logic [32:0]                        r_e2;
    logic                               r_res_status;
    logic [15:0]                        r_res_prob;

    logic                               r_out_valid;
    logic                               r_out_status;
    logic [15:0]                        r_out_prob;
    logic signed [7:0]                  r_out_rssi;
    logic                               r_out_cal;

    csi_mvd_pkg::t_div_req              r_div_req;
    csi_mvd_pkg::t_div_rsp              div_rsp;

    logic                               take;
    logic                               mem_we;
    logic [ADDR_W-1:0]                  wr_addr;
    logic [ADDR_W-1:0]                  rd_addr;
    logic                               frame_end;
    logic [WS_W-1:0]                    n_fc;
    logic [csi_mvd_pkg::SLOT_W-1:0]     n_slot;
    logic [15:0]                        n_tgt;
    logic [WS_W-1:0]                    n_ws;
    logic [5:0]                         cfg_ws;
    logic [csi_mvd_pkg::CSUM_W:0]       sum_wide;
    logic [31:0]                        net;
    logic [32:0]                        p_diff;
    logic                               load_out;
    logic [31:0]                        sq;
    logic [48:0]                        e_prod;

    csi_mvd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign take        = (r_state == ST_IDLE) && i_item_valid;
    assign o_item_take = take;
    assign mem_we      = take && (i_item.cmd == csi_mvd_pkg::CMD_SAMPLE);
    assign wr_addr     = ADDR_W'(r_slot) * ADDR_W'(csi_mvd_pkg::NSC) + ADDR_W'(r_sub);
    assign rd_addr     = ADDR_W'(r_i) * ADDR_W'(csi_mvd_pkg::NSC) + ADDR_W'(r_sc);
    assign frame_end   = (r_sub == csi_mvd_pkg::SC_W'(csi_mvd_pkg::NSC - 1));
    assign n_fc        = (r_fc < r_ws) ? r_fc + 1'b1 : r_fc;
    assign n_slot      = ((WS_W'(r_slot) + 1'b1) == r_ws) ? '0 : r_slot + 1'b1;
    assign cfg_ws      = i_cfg.data[5:0];
    assign sum_wide    = {1'b0, r_cal_sum} + (csi_mvd_pkg::CSUM_W + 1)'(r_avg);
    assign net         = (r_avg > r_base) ? r_avg - r_base : 32'd0;
    assign p_diff      = 33'h1_0000_0000 - r_e2;
    assign load_out    = (r_state == ST_OUT) && (!r_out_valid || i_pop);
    assign sq          = 32'(r_rd_data) * 32'(r_rd_data);
    assign e_prod      = 49'(r_e1) * 49'(csi_mvd_pkg::exp_lo(r_r[3:0]));

    always_comb begin
        if (i_item.calib_seconds == 16'd0) begin
            n_tgt = 16'd10;
        end else if (i_item.calib_seconds == 16'd1) begin
            n_tgt = 16'd1;
        end else begin
            n_tgt = i_item.calib_seconds >> 1;
        end
        if (cfg_ws < 6'd2) begin
            n_ws = WS_W'(2);
        end else if (int'(cfg_ws) > csi_mvd_pkg::WMAX) begin
            n_ws = WS_W'(csi_mvd_pkg::WMAX);
        end else begin
            n_ws = WS_W'(cfg_ws);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_item.amplitude;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_ws            <= WS_W'(16);
            r_thr           <= csi_mvd_pkg::THR_W'(419430);
            r_slot          <= '0;
            r_sub           <= '0;
            r_full          <= 1'b0;
            r_fc            <= '0;
            r_rssi          <= '0;
            r_seen          <= 1'b0;
            r_cal_act       <= 1'b1;
            r_cal_tgt       <= 16'd10;
            r_cal_cnt       <= '0;
            r_cal_sum       <= '0;
            r_base          <= '0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        case (i_item.cmd)
                            csi_mvd_pkg::CMD_SAMPLE: begin
                                r_sub <= frame_end ? '0 : r_sub + 1'b1;
                                if (frame_end) begin
                                    r_rssi <= i_item.rssi;
                                    r_seen <= 1'b1;
                                    r_slot <= n_slot;
                                    r_fc   <= n_fc;
                                    if (n_fc >= r_ws) begin
                                        r_full <= 1'b1;
                                    end
                                end
                            end
                            csi_mvd_pkg::CMD_CALIB: begin
                                r_cal_act <= 1'b1;
                                r_cal_tgt <= n_tgt;
                                r_cal_cnt <= '0;
                                r_cal_sum <= '0;
                            end
                            csi_mvd_pkg::CMD_COMPUTE: begin
                                r_res_prob <= '0;
                                if (!r_full) begin
                                    r_res_status <= 1'b1;
                                    r_state      <= ST_OUT;
                                end else begin
                                    r_res_status <= 1'b0;
                                    r_sc         <= '0;
                                    r_i          <= '0;
                                    r_pend       <= 1'b0;
                                    r_s          <= '0;
                                    r_q          <= '0;
                                    r_tot        <= '0;
                                    r_act        <= '0;
                                    r_state      <= ST_ACC;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ACC: begin
                    // walk the window slots of one subcarrier
                    if (r_i < r_ws) begin
                        r_i    <= r_i + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_s <= r_s + csi_mvd_pkg::S_W'(r_rd_data);
                        r_q <= r_q + csi_mvd_pkg::Q_W'(sq);
                    end
                    if ((r_i == r_ws) && !r_pend) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_s2    <= csi_mvd_pkg::S2_W'(r_s) * csi_mvd_pkg::S2_W'(r_s);
                    r_nq    <= csi_mvd_pkg::NQ_W'(r_ws) * csi_mvd_pkg::NQ_W'(r_q);
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_s >= csi_mvd_pkg::S_W'({r_ws, 8'd0})) begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= csi_mvd_pkg::DNUM_W'(r_nq - r_s2)
                                           << csi_mvd_pkg::FRAC_W;
                        r_div_req.den   <= r_s2;
                        r_kind          <= DK_CV2;
                        r_state         <= ST_DIV;
                    end else begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        case (r_kind)
                            DK_CV2: begin
                                r_tot   <= r_tot + csi_mvd_pkg::TOT_W'(div_rsp.quot);
                                r_act   <= r_act + 1'b1;
                                r_state <= ST_NEXT;
                            end
                            DK_AVG: begin
                                r_avg   <= div_rsp.quot;
                                r_state <= ST_POST;
                            end
                            DK_BASE: begin
                                r_base    <= div_rsp.quot;
                                r_cal_act <= 1'b0;
                                r_state   <= ST_OUT;
                            end
                            DK_PROB: begin
                                if (div_rsp.quot >= 32'(csi_mvd_pkg::R_SAT)) begin
                                    r_res_prob <= 16'hFFFF;
                                    r_state    <= ST_OUT;
                                end else begin
                                    r_r     <= div_rsp.quot[11:0];
                                    r_state <= ST_EXP1;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_NEXT: begin
                    if (r_sc == csi_mvd_pkg::SC_W'(csi_mvd_pkg::NSC - 1)) begin
                        r_state <= ST_AVG;
                    end else begin
                        r_sc    <= r_sc + 1'b1;
                        r_i     <= '0;
                        r_pend  <= 1'b0;
                        r_s     <= '0;
                        r_q     <= '0;
                        r_state <= ST_ACC;
                    end
                end
                ST_AVG: begin
                    if (r_act == '0) begin
                        r_avg   <= '0;
                        r_state <= ST_POST;
                    end else begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= csi_mvd_pkg::DNUM_W'(r_tot);
                        r_div_req.den   <= csi_mvd_pkg::DDEN_W'(r_act);
                        r_kind          <= DK_AVG;
                        r_state         <= ST_DIV;
                    end
                end
                ST_POST: begin
                    if (r_cal_act) begin
                        r_cal_sum <= sum_wide[csi_mvd_pkg::CSUM_W] ? '1
                                     : sum_wide[csi_mvd_pkg::CSUM_W-1:0];
                        r_cal_cnt <= r_cal_cnt + 1'b1;
                        r_state   <= ST_CAL2;
                    end else if (net == 32'd0) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= csi_mvd_pkg::DNUM_W'({net, 8'd0});
                        r_div_req.den   <= csi_mvd_pkg::DDEN_W'(r_thr);
                        r_kind          <= DK_PROB;
                        r_state         <= ST_DIV;
                    end
                end
                ST_CAL2: begin
                    if (r_cal_cnt >= r_cal_tgt) begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= csi_mvd_pkg::DNUM_W'(r_cal_sum);
                        r_div_req.den   <= csi_mvd_pkg::DDEN_W'(r_cal_tgt);
                        r_kind          <= DK_BASE;
                        r_state         <= ST_DIV;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_EXP1: begin
                    r_e1    <= 34'(csi_mvd_pkg::exp_int(r_r[11:8]))
                               * 34'(csi_mvd_pkg::exp_hi(r_r[7:4]));
                    r_state <= ST_EXP2;
                end
                ST_EXP2: begin
                    r_e2    <= e_prod[48:16];
                    r_state <= ST_EXP3;
                end
                ST_EXP3: begin
                    r_res_prob <= p_diff[32] ? 16'hFFFF : p_diff[31:16];
                    r_state    <= ST_OUT;
                end
                ST_OUT: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (i_cfg.we) begin
                if (i_cfg.idx == csi_mvd_pkg::CFG_WINDOW_SIZE) begin
                    r_ws   <= n_ws;
                    r_slot <= '0;
                    r_sub  <= '0;
                    r_full <= 1'b0;
                    r_fc   <= '0;
                end else begin
                    r_thr <= (i_cfg.data == '0) ? csi_mvd_pkg::THR_W'(1) : i_cfg.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_prob   <= r_res_prob;
            r_out_rssi   <= r_seen ? r_rssi : 8'sd0;
            r_out_cal    <= r_cal_act;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_status      = r_out_status;
    assign o_move_prob   = r_out_prob;
    assign o_last_rssi   = r_out_rssi;
    assign o_calibrating = r_out_cal;

endmodule

### rtl/csi_motion_variance_detector.sv
// Top level of the CSI motion variance detector: front queue plus back end.
// Depends on csi_mvd_pkg, csi_mvd_front and csi_mvd_back.
//
// Items enter through a queue interface (push/full) and are decoded into a
// two-entry queue; results leave through a one-deep result queue (empty/pop).
// The back end takes an amplitude sample or a calibration start while idle
// and stays idle, so a stream of samples runs at one item a cycle while no
// compute is in progress. A compute item with a full window walks the window
// memory one slot a cycle for each subcarrier and runs the shared bit-serial
// divider once per active subcarrier, then for the average if any subcarrier
// is active, and at most once more for the baseline or the probability, the
// latter followed by the exponent steps; the single read port of the window
// memory and the bit-serial divider bound how long a compute takes. A compute
// item before the window is full answers with status 1 without a walk. The
// window store (WMAX x NSC amplitudes) is not cleared after reset; only slots
// filled since the last window length write are ever read.
// Write configuration only while the block is idle.
module csi_motion_variance_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_func,
    input  logic [15:0]                     i_amplitude,
    input  logic signed [7:0]               i_rssi,
    input  logic [15:0]                     i_calib_seconds,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_status,
    output logic [15:0]                     o_move_prob,
    output logic signed [7:0]               o_last_rssi,
    output logic                            o_calibrating,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [csi_mvd_pkg::CFG_W-1:0]   i_cfg_data
);

    csi_mvd_pkg::t_item     item;
    logic                   item_valid;
    logic                   item_take;
    csi_mvd_pkg::t_cfg_wr   cfg;

    // bundle the register write port
    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    csi_mvd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_func          (i_func),
        .i_amplitude     (i_amplitude),
        .i_rssi          (i_rssi),
        .i_calib_seconds (i_calib_seconds),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_item_take     (item_take)
    );

    csi_mvd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_take   (item_take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_status      (o_status),
        .o_move_prob   (o_move_prob),
        .o_last_rssi   (o_last_rssi),
        .o_calibrating (o_calibrating)
    );

endmodule

### tb/tb_csi_motion_variance_detector.sv
// Self-checking testbench for the CSI motion variance detector.
// Depends on csi_mvd_pkg and the csi_motion_variance_detector top level.
`timescale 1ns / 1ps

typedef struct packed {
    bit              status;
    bit [15:0]       prob;
    bit signed [7:0] rssi;
    bit              calibrating;
} t_reading;

// Tracks the detector's state, predicts each compute reading and checks the
// readings that come back in order.
class mvd_reading_board;
    localparam int NSC  = csi_mvd_pkg::NSC;
    localparam int WMAX = csi_mvd_pkg::WMAX;

    bit [15:0]      win_amp [WMAX*NSC];
    int unsigned    win_len, cv2_div, slot, sub_pos, frames;
    bit             win_full, frame_seen, cal_on;
    bit [7:0]       last_rssi_q;
    int unsigned    cal_target, cal_count;
    bit [63:0]      cal_sum;
    bit [31:0]      baseline;
    t_reading       pending_readings[$];
    int             mismatches;

    function new();
        win_len = 16; cv2_div = 419430;
        slot = 0; sub_pos = 0; frames = 0; win_full = 0;
        frame_seen = 0; last_rssi_q = 0;
        cal_on = 1; cal_target = 10; cal_count = 0; cal_sum = 0; baseline = 0;
        mismatches = 0;
    endfunction

    function void write_reg(bit idx, bit [23:0] data);
        bit [63:0] v;
        if (idx == csi_mvd_pkg::CFG_WINDOW_SIZE) begin
            v = data & 24'h3F;
            if (v < 2) v = 2;
            if (v > WMAX) v = WMAX;
            win_len = 32'(v);
            slot = 0; sub_pos = 0; frames = 0; win_full = 0;
        end else begin
            cv2_div = (data == 0) ? 1 : data;
        end
    endfunction

    // Relative variance of one subcarrier in Q8.24; zero return means inactive.
    function bit sc_cv2(int sc, output bit [31:0] cv2);
        bit [63:0] s, q, x, s2, d, ip, rem, frac;
        s = 0; q = 0; cv2 = 0;
        for (int i = 0; i < win_len; i++) begin
            x = win_amp[i*NSC + sc];
            s += x;
            q += x * x;
        end
        if (s < 256 * win_len) return 0;
        s2 = s * s;
        d = win_len * q - s2;
        ip = d / s2;
        rem = d % s2;
        frac = 0;
        if (ip > 255) begin
            cv2 = 32'hFFFF_FFFF;
            return 1;
        end
        for (int b = 0; b < 24; b++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= s2) begin
                rem -= s2;
                frac |= 1;
            end
        end
        cv2 = 32'((ip << 24) | frac);
        return 1;
    endfunction

    function bit [15:0] prob_of_net(bit [31:0] net);
        bit [63:0] r, e, p;
        r = 64'({32'd0, net, 8'd0} / cv2_div);
        if ((r >> 8) >= 12) return 16'hFFFF;
        e = csi_mvd_pkg::exp_int(r[11:8]) * csi_mvd_pkg::exp_hi(r[7:4]);
        e = (e * csi_mvd_pkg::exp_lo(r[3:0])) >> 16;
        p = (64'h1_0000_0000 - e) >> 16;
        return (p > 65535) ? 16'hFFFF : p[15:0];
    endfunction

    function void note_item(bit [1:0] fn, bit [15:0] amp, bit [7:0] rssi, bit [15:0] secs);
        t_reading rd;
        bit [63:0] total, b;
        bit [31:0] c, avg, net;
        int unsigned act, t;
        case (fn)
            csi_mvd_pkg::FUNC_SAMPLE: begin
                win_amp[slot*NSC + sub_pos] = amp;
                sub_pos++;
                if (sub_pos >= NSC) begin
                    sub_pos = 0;
                    last_rssi_q = rssi;
                    frame_seen = 1;
                    slot = (slot + 1) % win_len;
                    if (frames < win_len) frames++;
                    if (frames >= win_len) win_full = 1;
                end
            end
            csi_mvd_pkg::FUNC_CALIB: begin
                t = (secs > 0) ? secs / 2 : 10;
                if (t == 0) t = 1;
                cal_on = 1; cal_target = t; cal_count = 0; cal_sum = 0;
            end
            csi_mvd_pkg::FUNC_COMPUTE: begin
                rd.status = 1;
                rd.prob = 0;
                if (win_full) begin
                    rd.status = 0;
                    total = 0; act = 0;
                    for (int sc = 0; sc < NSC; sc++)
                        if (sc_cv2(sc, c)) begin
                            total += c;
                            act++;
                        end
                    avg = act ? 32'(total / act) : 32'd0;
                    if (cal_on) begin
                        cal_sum += avg;
                        if (cal_sum > 64'hFF_FFFF_FFFF) cal_sum = 64'hFF_FFFF_FFFF;
                        cal_count++;
                        if (cal_count >= cal_target) begin
                            b = cal_sum / cal_target;
                            baseline = (b > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : b[31:0];
                            cal_on = 0;
                        end
                    end else begin
                        net = (avg > baseline) ? avg - baseline : 0;
                        rd.prob = net ? prob_of_net(net) : 16'd0;
                    end
                end
                rd.rssi = frame_seen ? last_rssi_q : 8'd0;
                rd.calibrating = cal_on;
                pending_readings.push_back(rd);
            end
            default: ;  // spare code: ignored by the block
        endcase
    endfunction

    function void check_reading(t_reading got);
        t_reading exp_rd;
        if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected reading status=%0d prob=%0d rssi=%0d cal=%0d",
                         got.status, got.prob, got.rssi, got.calibrating);
            return;
        end
        exp_rd = pending_readings.pop_front();
        if (exp_rd != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: reading exp status=%0d prob=%0d rssi=%0d cal=%0d, got %0d %0d %0d %0d",
                         exp_rd.status, exp_rd.prob, exp_rd.rssi, exp_rd.calibrating,
                         got.status, got.prob, got.rssi, got.calibrating);
        end
    endfunction
endclass

module tb_csi_motion_variance_detector;

    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [1:0]                     i_func = csi_mvd_pkg::FUNC_SAMPLE;
    logic [15:0]                    i_amplitude = '0;
    logic signed [7:0]              i_rssi = '0;
    logic [15:0]                    i_calib_seconds = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           o_status;
    logic [15:0]                    o_move_prob;
    logic signed [7:0]              o_last_rssi;
    logic                           o_calibrating;
    logic                           i_cfg_we = 1'b0;
    logic                           i_cfg_idx = 1'b0;
    logic [csi_mvd_pkg::CFG_W-1:0]  i_cfg_data = '0;

    mvd_reading_board board = new();

    int  rx_gap = 0;
    int  rx_hold = 0;     // long receiver hold-off, set by the stimulus
    bit  tx_eager = 0;    // sender runs without gaps while set
    int  amp_mode = 0;
    bit [15:0] sc_base [csi_mvd_pkg::NSC];

    csi_motion_variance_detector u_top (.*);

    always #1 i_clk = ~i_clk;

    // Receiver: check each accepted reading, then draw the next pause.
    always @(posedge i_clk) begin
        t_reading got;
        if (i_rst_n && pop && !empty) begin
            got.status = o_status;
            got.prob = o_move_prob;
            got.rssi = o_last_rssi;
            got.calibrating = o_calibrating;
            board.check_reading(got);
            rx_gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 10);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Offer one item after a random gap and hold it until accepted.
    task automatic send_item(logic [1:0] fn, logic [15:0] amp, logic signed [7:0] rssi,
                             logic [15:0] secs);
        int gap;
        gap = (tx_eager || $urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_func <= fn;
        i_amplitude <= amp;
        i_rssi <= rssi;
        i_calib_seconds <= secs;
        do @(posedge i_clk); while (full);
        board.note_item(fn, amp, rssi, secs);
    endtask

    function automatic logic signed [7:0] rand_rssi();
        return 8'(-$signed({1'b0, 8'($urandom_range(0, 128))}));
    endfunction

    // Amplitude for one subcarrier, shaped by the current phase's profile.
    function automatic logic [15:0] next_amp(int sc);
        int r, v;
        r = $urandom_range(0, 99);
        if (r < 3) return 16'h0000;
        if (r < 6) return 16'hFFFF;
        case (amp_mode)
            0:       v = sc_base[sc];
            1:       v = sc_base[sc] + $urandom_range(0, 15);
            2:       v = sc_base[sc] + $urandom_range(0, sc_base[sc] / 8 + 1);
            default: v = $urandom_range(0, 65535);
        endcase
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic send_samples(int count);
        repeat (count) send_item(csi_mvd_pkg::FUNC_SAMPLE, next_amp(board.sub_pos),
                                 rand_rssi(), 16'($urandom));
    endtask

    // Hold input until every reading is back and in-flight items have retired.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (board.pending_readings.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Write the threshold, and the window length first unless win_raw is negative.
    task automatic write_regs(int win_raw, logic [23:0] thr_raw);
        if (win_raw >= 0) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= csi_mvd_pkg::CFG_WINDOW_SIZE;
            i_cfg_data <= 24'(win_raw);
            @(posedge i_clk);
            board.write_reg(csi_mvd_pkg::CFG_WINDOW_SIZE, 24'(win_raw));
        end
        i_cfg_we <= 1'b1;
        i_cfg_idx <= csi_mvd_pkg::CFG_CV2_THRESHOLD;
        i_cfg_data <= thr_raw;
        @(posedge i_clk);
        board.write_reg(csi_mvd_pkg::CFG_CV2_THRESHOLD, thr_raw);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One setting: configure, fill the window if restarted, then compute amid
    // partial frames.
    task automatic run_phase(int win_raw, logic [23:0] thr_raw, int calib_secs,
                             int mode, int rounds, bit squeeze);
        int r;
        drain();
        write_regs(win_raw, thr_raw);
        amp_mode = mode;
        foreach (sc_base[i])
            sc_base[i] = (mode == 1) ? $urandom_range(0, 300) : $urandom_range(256, 60000);
        if (calib_secs >= 0) send_item(csi_mvd_pkg::FUNC_CALIB, '0, '0, calib_secs[15:0]);
        send_item(csi_mvd_pkg::FUNC_COMPUTE, '0, '0, '0);
        send_item(FUNC_SPARE, 16'($urandom), rand_rssi(), 16'($urandom));
        if (win_raw >= 0) send_samples(board.win_len * csi_mvd_pkg::NSC);
        if (squeeze) rx_hold = 12000;   // readings pile up, input stalls
        repeat (rounds) begin
            r = $urandom_range(0, 19);
            send_samples($urandom_range(0, 8));
            if (r == 0) send_item(FUNC_SPARE, 16'($urandom), rand_rssi(), 16'($urandom));
            if (r == 1) send_item(csi_mvd_pkg::FUNC_CALIB, '0, '0,
                                  16'($urandom_range(0, 12)));
            send_item(csi_mvd_pkg::FUNC_COMPUTE, 16'($urandom), rand_rssi(), 16'($urandom));
            if (squeeze) send_item(csi_mvd_pkg::FUNC_COMPUTE, '0, '0, '0);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset settings: window of 16 not yet full after one frame
        drain();
        amp_mode = 2;
        foreach (sc_base[i]) sc_base[i] = $urandom_range(256, 60000);
        send_item(csi_mvd_pkg::FUNC_COMPUTE, '0, '0, '0);
        send_samples(csi_mvd_pkg::NSC);
        send_item(csi_mvd_pkg::FUNC_COMPUTE, '0, '0, '0);
        // clamped window lengths, threshold extremes and calibration lengths
        run_phase(24'hFFFF00, 24'd0,        1,     2, 6, 0);
        run_phase(-1,         24'hFFFFFF,   0,     0, 12, 0);
        run_phase(1,          24'd419430,   -1,    1, 6, 1);
        tx_eager = 1;
        run_phase(-1,         24'd20000,    6,     3, 6, 0);
        tx_eager = 0;
        run_phase(3,          24'd2000000,  65535, 2, 3, 0);
        run_phase(-1,         24'd1,        4,     2, 5, 0);
        drain();
        if (board.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
